// File: rtl/ubfb_pkg.sv
// types and constants shared by the udp broadcast frame builder
package ubfb_pkg;

  localparam int HDR_BYTES = 42;
  localparam int HDR_BITS  = HDR_BYTES * 8;

  localparam logic [0:0] ACT_START = 1'b0;
  localparam logic [0:0] ACT_BYTE  = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
  localparam logic [1:0] STATUS_SEQ     = 2'd2;

  localparam logic [7:0] REG_SOURCE_MAC  = 8'd0;
  localparam logic [7:0] REG_SOURCE_IPV4 = 8'd1;
  localparam logic [7:0] REG_SOURCE_PORT = 8'd2;
  localparam logic [7:0] REG_DEST_PORT   = 8'd3;

  localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] IP_VER_TOS = 16'h4500;
  localparam logic [7:0]  IP_TTL     = 8'd64;
  localparam logic [7:0]  IP_PROTO   = 8'd17;
  localparam logic [31:0] BCAST_IP   = 32'hFFFF_FFFF;
  localparam logic [15:0] IP_UDP_HDR = 16'd28;
  localparam logic [15:0] UDP_HDR    = 16'd8;

  // 0x4500 + 0x4011 + 0xffff + 0xffff
  localparam logic [18:0] CSUM_BASE = 19'h2850F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_HDR,
    ST_PAD
  } state_t;

  typedef struct packed {
    logic [0:0]  action;
    logic [10:0] payload_length;
    logic [7:0]  payload_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
    logic [1:0] status;
  } out_beat_t;

endpackage

// File: rtl/udp_broadcast_frame_builder_core.sv
// udp broadcast frame builder: header shift register, checksum sequencer, padding
//
// Usage: write source_mac, source_ipv4, source_port and destination_port on the
// cfg channel (index 0..3, always ready) while no frame is in flight. On the in
// channel a start beat (action 0) gives the payload length; the block then adds
// the source IPv4 words into the header checksum one 16-bit word per cycle, folds
// the carry, loads the 42-byte header into a shift register and sends it one
// byte per cycle while out_stall is low. Each payload beat (action 1) passes its
// byte through the output register, so payload runs at one byte per cycle while
// out_stall is low. After the last payload byte the frame is zero-padded to
// MIN_FRAME_BYTES and end_of_frame marks the final byte. Bad items give one beat
// with a nonzero status. Results leave through a single output register; when
// out_stall is high a valid beat holds and the in channel, header and padding
// wait, but not the checksum steps. Reset (rst, synchronous) clears the control
// and config registers (not acc, hdr_sr or out_data), closes any open frame and
// empties the output register.
module udp_broadcast_frame_builder_core #(
  parameter int MAX_PAYLOAD     = 1472,
  parameter int MIN_FRAME_BYTES = 60
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ubfb_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ubfb_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_index,
  input  logic [47:0]         cfg_data
);

  localparam int PAD_MAX = MIN_FRAME_BYTES - ubfb_pkg::HDR_BYTES;
  localparam int PAD_W   = $clog2(PAD_MAX + 2);
  localparam logic [10:0] PAD_MAX_L = 11'(PAD_MAX);
  localparam logic [10:0] MAX_LEN_L = 11'(MAX_PAYLOAD);
  localparam logic [5:0]  HDR_LAST  = 6'(ubfb_pkg::HDR_BYTES - 1);
  localparam int HB = ubfb_pkg::HDR_BITS;

  logic [47:0] source_mac;
  logic [31:0] source_ipv4;
  logic [15:0] source_port;
  logic [15:0] destination_port;

  ubfb_pkg::state_t state, state_next;
  logic        frame_open, frame_open_next;
  logic [10:0] bytes_left, bytes_left_next;
  logic [10:0] pay_len, pay_len_next;
  logic [18:0] acc, acc_next;
  logic [1:0]  sum_cnt, sum_cnt_next;
  logic [5:0]  hdr_cnt, hdr_cnt_next;
  logic [HB-1:0] hdr_sr, hdr_sr_next;
  logic [PAD_W-1:0] pad_left, pad_left_next;
  logic        out_valid_next;
  ubfb_pkg::out_beat_t out_data_next;

  logic        adv;
  logic [18:0] acc_fold;
  logic [15:0] ck;
  logic [15:0] ip_len;
  logic [15:0] udp_len;
  logic [PAD_W-1:0] pad_frame;
  logic [PAD_W-1:0] pad_hdr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac       <= '0;
      source_ipv4      <= '0;
      source_port      <= '0;
      destination_port <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ubfb_pkg::REG_SOURCE_MAC:  source_mac       <= cfg_data;
        ubfb_pkg::REG_SOURCE_IPV4: source_ipv4      <= cfg_data[31:0];
        ubfb_pkg::REG_SOURCE_PORT: source_port      <= cfg_data[15:0];
        ubfb_pkg::REG_DEST_PORT:   destination_port <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign acc_fold = 19'(acc[15:0]) + 19'(acc[18:16]);
  assign ck       = ~acc_fold[15:0];
  assign ip_len   = 16'(pay_len) + ubfb_pkg::IP_UDP_HDR;
  assign udp_len  = 16'(pay_len) + ubfb_pkg::UDP_HDR;
  assign pad_frame = (pay_len < PAD_MAX_L) ? PAD_W'(PAD_MAX_L - pay_len) : '0;
  assign pad_hdr   = PAD_W'(PAD_MAX_L);

  always_comb begin
    state_next      = state;
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    pay_len_next    = pay_len;
    acc_next        = acc;
    sum_cnt_next    = sum_cnt;
    hdr_cnt_next    = hdr_cnt;
    hdr_sr_next     = hdr_sr;
    pad_left_next   = pad_left;
    out_valid_next  = out_valid && out_stall;
    out_data_next   = out_data;
    in_stall        = 1'b1;

    unique case (state)
      ubfb_pkg::ST_IDLE: begin
        in_stall = !adv;
        if (in_valid && adv) begin
          out_valid_next = 1'b1;
          out_data_next  = '{frame_byte: 8'h00, end_of_frame: 1'b0,
                             status: ubfb_pkg::STATUS_SEQ};
          if (in_data.action == ubfb_pkg::ACT_START) begin
            if (frame_open) begin
              out_valid_next = 1'b1;
            end else if (in_data.payload_length > MAX_LEN_L) begin
              out_data_next.status = ubfb_pkg::STATUS_TOO_BIG;
            end else begin
              out_valid_next = 1'b0;
              pay_len_next   = in_data.payload_length;
              acc_next       = ubfb_pkg::CSUM_BASE + 19'(ubfb_pkg::IP_UDP_HDR)
                             + 19'(in_data.payload_length);
              sum_cnt_next   = '0;
              state_next     = ubfb_pkg::ST_SUM;
            end
          end else if (frame_open && bytes_left != '0) begin
            bytes_left_next          = bytes_left - 11'd1;
            out_data_next.frame_byte = in_data.payload_byte;
            out_data_next.status     = ubfb_pkg::STATUS_OK;
            if (bytes_left == 11'd1) begin
              frame_open_next            = 1'b0;
              out_data_next.end_of_frame = (pad_frame == '0);
              if (pad_frame != '0) begin
                pad_left_next = pad_frame;
                state_next    = ubfb_pkg::ST_PAD;
              end
            end
          end
        end
      end
      ubfb_pkg::ST_SUM: begin
        sum_cnt_next = sum_cnt + 2'd1;
        case (sum_cnt)
          2'd0: acc_next = acc + 19'(source_ipv4[31:16]);
          2'd1: acc_next = acc + 19'(source_ipv4[15:0]);
          2'd2: acc_next = acc_fold;
          default: begin
            hdr_sr_next = {ubfb_pkg::BCAST_MAC, source_mac, ubfb_pkg::ETH_IPV4,
                           ubfb_pkg::IP_VER_TOS, ip_len, 32'h0,
                           ubfb_pkg::IP_TTL, ubfb_pkg::IP_PROTO, ck, source_ipv4,
                           ubfb_pkg::BCAST_IP, source_port, destination_port,
                           udp_len, 16'h0};
            hdr_cnt_next = '0;
            state_next   = ubfb_pkg::ST_HDR;
          end
        endcase
      end
      ubfb_pkg::ST_HDR: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_data_next  = '{frame_byte: hdr_sr[HB-1 -: 8], end_of_frame: 1'b0,
                             status: ubfb_pkg::STATUS_OK};
          hdr_sr_next    = {hdr_sr[HB-9:0], 8'h00};
          hdr_cnt_next   = hdr_cnt + 6'd1;
          if (hdr_cnt == HDR_LAST) begin
            state_next = ubfb_pkg::ST_IDLE;
            if (pay_len == '0) begin
              out_data_next.end_of_frame = (pad_hdr == '0);
              if (pad_hdr != '0) begin
                pad_left_next = pad_hdr;
                state_next    = ubfb_pkg::ST_PAD;
              end
            end else begin
              frame_open_next = 1'b1;
              bytes_left_next = pay_len;
            end
          end
        end
      end
      ubfb_pkg::ST_PAD: begin
        if (adv) begin
          out_valid_next = 1'b1;
          out_data_next  = '{frame_byte: 8'h00, end_of_frame: (pad_left == PAD_W'(1)),
                             status: ubfb_pkg::STATUS_OK};
          pad_left_next  = pad_left - PAD_W'(1);
          if (pad_left == PAD_W'(1)) begin
            state_next = ubfb_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = ubfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ubfb_pkg::ST_IDLE;
      frame_open <= 1'b0;
      bytes_left <= '0;
      pay_len    <= '0;
      out_valid  <= 1'b0;
      sum_cnt    <= '0;
      hdr_cnt    <= '0;
      pad_left   <= '0;
    end else begin
      state      <= state_next;
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
      pay_len    <= pay_len_next;
      out_valid  <= out_valid_next;
      sum_cnt    <= sum_cnt_next;
      hdr_cnt    <= hdr_cnt_next;
      pad_left   <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    hdr_sr   <= hdr_sr_next;
    out_data <= out_data_next;
  end

  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_left != '0)
    else $error("open frame with no bytes left");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ubfb_pkg::ST_PAD |-> pad_left != '0)
    else $error("padding with empty count");

  a_err_beat_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ubfb_pkg::STATUS_OK
      |-> !out_data.end_of_frame && out_data.frame_byte == 8'h00)
    else $error("error beat carries data");

  a_hdr_closed: assert property (@(posedge clk) disable iff (rst)
    (state == ubfb_pkg::ST_HDR || state == ubfb_pkg::ST_SUM) |-> !frame_open)
    else $error("header sent while a frame is open");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != ubfb_pkg::ST_IDLE |=> $past(state) == ubfb_pkg::ST_IDLE || $past(in_stall))
    else $error("item taken while busy");

endmodule

// File: tb/tb_top.sv
// testbench for the udp broadcast frame builder: directed table, random frames, checked per byte
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_LEN   = 1472;
  localparam int MIN_FRAME = 60;
  localparam int SETTLE    = 64;

  typedef struct packed {
    logic       chk;
    logic [1:0] st;
    logic [0:0] act;
    logic [10:0] len;
    logic [7:0] pb;
  } dir_row_t;

  // rows with chk set carry their single error beat, the others go to the frame model
  localparam dir_row_t DIR_TAB [14] = '{
    '{1'b1, ubfb_pkg::STATUS_SEQ,     ubfb_pkg::ACT_BYTE,  11'd0,    8'hA5},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_START, 11'd0,    8'hFF},
    '{1'b1, ubfb_pkg::STATUS_TOO_BIG, ubfb_pkg::ACT_START, 11'd1473, 8'h00},
    '{1'b1, ubfb_pkg::STATUS_TOO_BIG, ubfb_pkg::ACT_START, 11'd2047, 8'hFF},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_START, 11'd1,    8'h3C},
    '{1'b1, ubfb_pkg::STATUS_SEQ,     ubfb_pkg::ACT_START, 11'd3,    8'h00},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_BYTE,  11'd0,    8'hFF},
    '{1'b1, ubfb_pkg::STATUS_SEQ,     ubfb_pkg::ACT_BYTE,  11'd2047, 8'h00},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_START, 11'd2,    8'h00},
    '{1'b1, ubfb_pkg::STATUS_SEQ,     ubfb_pkg::ACT_START, 11'd1473, 8'hFF},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_BYTE,  11'd2047, 8'h00},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_BYTE,  11'd0,    8'h5A},
    '{1'b1, ubfb_pkg::STATUS_SEQ,     ubfb_pkg::ACT_BYTE,  11'd0,    8'hFF},
    '{1'b0, ubfb_pkg::STATUS_OK,      ubfb_pkg::ACT_START, 11'd0,    8'h00}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ubfb_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ubfb_pkg::out_beat_t out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [7:0]          cfg_index = '0;
  logic [47:0]         cfg_data = '0;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  logic [47:0] cur_mac   = '0;
  logic [31:0] cur_ip    = '0;
  logic [15:0] cur_sport = '0;
  logic [15:0] cur_dport = '0;
  logic        open_frame = 1'b0;
  logic [10:0] bytes_left = '0;
  logic [10:0] open_len   = '0;

  ubfb_pkg::out_beat_t expected_bytes [$];
  ubfb_pkg::out_beat_t want;
  int unsigned fails = 0;

  udp_broadcast_frame_builder_core #(
    .MAX_PAYLOAD     (MAX_LEN),
    .MIN_FRAME_BYTES (MIN_FRAME)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d beats outstanding", expected_bytes.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] b, input logic eof,
                                    input logic [1:0] st);
    ubfb_pkg::out_beat_t o;
    o.frame_byte   = b;
    o.end_of_frame = eof;
    o.status       = st;
    expected_bytes.push_back(o);
  endfunction

  function automatic void pad_frame(input int unsigned len);
    int unsigned total;
    total = ubfb_pkg::HDR_BYTES + len;
    while (total < MIN_FRAME) begin
      total++;
      push_byte(8'h00, (total == MIN_FRAME) ? 1'b1 : 1'b0, ubfb_pkg::STATUS_OK);
    end
  endfunction

  function automatic void build_frame_bytes(input ubfb_pkg::in_beat_t b);
    logic [15:0]                   ip_len;
    logic [15:0]                   udp_len;
    logic [31:0]                   sum;
    logic [15:0]                   ck;
    logic [ubfb_pkg::HDR_BITS-1:0] hdr;
    logic                          eof;
    if (b.action == ubfb_pkg::ACT_START) begin
      if (open_frame) begin
        push_byte(8'h00, 1'b0, ubfb_pkg::STATUS_SEQ);
        return;
      end
      if (b.payload_length > MAX_LEN) begin
        push_byte(8'h00, 1'b0, ubfb_pkg::STATUS_TOO_BIG);
        return;
      end
      ip_len  = ubfb_pkg::IP_UDP_HDR + 16'(b.payload_length);
      udp_len = ubfb_pkg::UDP_HDR + 16'(b.payload_length);
      sum = 32'(ubfb_pkg::IP_VER_TOS) + 32'(ip_len)
          + 32'({ubfb_pkg::IP_TTL, ubfb_pkg::IP_PROTO})
          + 32'(cur_ip[31:16]) + 32'(cur_ip[15:0]) + 32'hFFFF + 32'hFFFF;
      sum = 32'(sum[15:0]) + 32'(sum[31:16]);
      sum = 32'(sum[15:0]) + 32'(sum[31:16]);
      ck  = ~sum[15:0];
      hdr = {ubfb_pkg::BCAST_MAC, cur_mac, ubfb_pkg::ETH_IPV4, ubfb_pkg::IP_VER_TOS,
             ip_len, 32'h0, ubfb_pkg::IP_TTL, ubfb_pkg::IP_PROTO, ck, cur_ip,
             ubfb_pkg::BCAST_IP, cur_sport, cur_dport, udp_len, 16'h0};
      open_len = b.payload_length;
      for (int i = 0; i < ubfb_pkg::HDR_BYTES; i++) begin
        eof = (b.payload_length == 0 && i == ubfb_pkg::HDR_BYTES - 1
               && MIN_FRAME <= ubfb_pkg::HDR_BYTES);
        push_byte(hdr[ubfb_pkg::HDR_BITS - 1 - 8 * i -: 8], eof, ubfb_pkg::STATUS_OK);
      end
      if (b.payload_length == 0) begin
        open_frame = 1'b0;
        bytes_left = '0;
        pad_frame(0);
      end else begin
        open_frame = 1'b1;
        bytes_left = b.payload_length;
      end
      return;
    end
    if (!open_frame || bytes_left == 0) begin
      push_byte(8'h00, 1'b0, ubfb_pkg::STATUS_SEQ);
      return;
    end
    bytes_left = bytes_left - 11'd1;
    if (bytes_left != 0) begin
      push_byte(b.payload_byte, 1'b0, ubfb_pkg::STATUS_OK);
      return;
    end
    open_frame = 1'b0;
    push_byte(b.payload_byte, (ubfb_pkg::HDR_BYTES + open_len >= MIN_FRAME) ? 1'b1 : 1'b0,
              ubfb_pkg::STATUS_OK);
    pad_frame(open_len);
  endfunction

  // random idle before each beat unless quiet, then hold it until taken
  task automatic send_beat(input ubfb_pkg::in_beat_t b);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer(input ubfb_pkg::in_beat_t b, inout int unsigned sent);
    send_beat(b);
    build_frame_bytes(b);
    sent++;
  endtask

  task automatic send_frame(input int unsigned len, inout int unsigned sent);
    ubfb_pkg::in_beat_t b;
    b = '{action: ubfb_pkg::ACT_START, payload_length: 11'(len),
          payload_byte: 8'($urandom)};
    offer(b, sent);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) begin
        b = '{action: ubfb_pkg::ACT_START, payload_length: 11'($urandom),
              payload_byte: 8'($urandom)};
        offer(b, sent);
      end
      b = '{action: ubfb_pkg::ACT_BYTE, payload_length: 11'($urandom),
            payload_byte: 8'($urandom)};
      offer(b, sent);
    end
  endtask

  task automatic random_frames(input int unsigned n_items);
    int unsigned        sent;
    int unsigned        pick;
    int unsigned        len;
    ubfb_pkg::in_beat_t b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        b = '{action: ubfb_pkg::ACT_BYTE, payload_length: 11'($urandom),
              payload_byte: 8'($urandom)};
        offer(b, sent);
      end else if (pick < 9) begin
        b = '{action: ubfb_pkg::ACT_START,
              payload_length: 11'($urandom_range(2047, MAX_LEN + 1)),
              payload_byte: 8'($urandom)};
        offer(b, sent);
      end else begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(40, 0);
        else if (pick < 95) len = $urandom_range(200, 41);
        else len = $urandom_range(400, 201);
        send_frame(len, sent);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ubfb_pkg::REG_SOURCE_MAC: cur_mac = val;
      ubfb_pkg::REG_SOURCE_IPV4: cur_ip = val[31:0];
      ubfb_pkg::REG_SOURCE_PORT: cur_sport = val[15:0];
      ubfb_pkg::REG_DEST_PORT: cur_dport = val[15:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register's width carry junk on purpose
  task automatic load_regs(input logic [47:0] mac, input logic [47:0] ip,
                           input logic [47:0] sport, input logic [47:0] dport);
    write_reg(ubfb_pkg::REG_SOURCE_MAC, mac);
    write_reg(8'($urandom_range(255, 4)), {16'($urandom), 32'($urandom)});
    write_reg(ubfb_pkg::REG_SOURCE_IPV4, ip);
    write_reg(ubfb_pkg::REG_SOURCE_PORT, sport);
    write_reg(ubfb_pkg::REG_DEST_PORT, dport);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin : rx_side
    int unsigned hold_left;
    bit          hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 23);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%0t: unexpected beat byte %h eof %b status %0d",
                                  $time, out_data.frame_byte, out_data.end_of_frame,
                                  out_data.status);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.frame_byte !== want.frame_byte
            || out_data.end_of_frame !== want.end_of_frame
            || out_data.status !== want.status) begin
          fails++;
          if (fails <= 10)
            $display("%0t: exp byte %h eof %b status %0d, got byte %h eof %b status %0d",
                     $time, want.frame_byte, want.end_of_frame, want.status,
                     out_data.frame_byte, out_data.end_of_frame, out_data.status);
        end
      end
    end
  end

  initial begin : stimulus
    ubfb_pkg::in_beat_t b;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers still at reset value
    foreach (DIR_TAB[i]) begin
      b = '{action: DIR_TAB[i].act, payload_length: DIR_TAB[i].len,
            payload_byte: DIR_TAB[i].pb};
      send_beat(b);
      if (DIR_TAB[i].chk) push_byte(8'h00, 1'b0, DIR_TAB[i].st);
      else build_frame_bytes(b);
    end
    in_valid <= 1'b0;
    drain();

    load_regs(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
              48'hFFFF_FFFF_FFFF);
    hold_req <= 1'b1;
    random_frames(130);
    drain();

    load_regs({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
              {16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)});
    random_frames(130);
    drain();

    load_regs(48'h0, {16'($urandom), 32'h0}, {32'($urandom), 16'h0},
              {32'($urandom), 16'h0});
    quiet <= 1'b1;
    random_frames(120);
    drain();

    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/ubfb_pkg.sv
rtl/udp_broadcast_frame_builder_core.sv
tb/tb_top.sv
